>>> hdl/rtpts_pkg.sv
package rtpts_pkg;

  // Controller states: four packet modes plus the two steps of a header release.
  typedef enum logic [2:0] {
    ST_START,
    ST_COLLECT,
    ST_PLAIN,
    ST_STAMPED,
    ST_RD,
    ST_LOAD
  } rtpts_state_t;

  // Configuration register indexes.
  localparam logic [7:0] CFG_PERIOD = 8'd0;
  localparam logic [7:0] CFG_EXT_ID = 8'd1;

  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic [3:0]  EXT_ID_RESET = 4'd1;

  localparam logic [6:0] FIXED_HDR_BYTES = 7'd12;
  localparam logic [1:0] RTP_VERSION     = 2'd2;
  localparam logic [7:0] X_BIT_MASK      = 8'h10;

  // Extension block: profile BEDE, length 3 words, element of 8 data bytes.
  localparam logic [7:0] EXT_PROFILE_HI = 8'hBE;
  localparam logic [7:0] EXT_PROFILE_LO = 8'hDE;
  localparam logic [7:0] EXT_LEN_HI     = 8'h00;
  localparam logic [7:0] EXT_LEN_LO     = 8'h03;
  localparam logic [3:0] EXT_ELEM_LEN   = 4'h7;
  localparam int unsigned EXT_GROUPS    = 4;

  // Write port of the header store: one byte lane of one row per cycle.
  typedef struct packed {
    logic       en;
    logic [1:0] lane;
    logic [7:0] data;
  } hdr_wr_t;

endpackage

>>> hdl/rtpts_hdr_mem.sv
module rtpts_hdr_mem
  import rtpts_pkg::*;
#(
  parameter int unsigned ROWS   = 18,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk,
  input  hdr_wr_t           wr,
  input  logic [ADDR_W-1:0] wr_row,
  input  logic [ADDR_W-1:0] rd_row,
  output logic [31:0]       rd_data
);

  // Header bytes packed four to a row, byte 0 of the packet in lane 0 of row 0.
  logic [31:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_row][8*wr.lane +: 8] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_row];
  end

endmodule

>>> hdl/rtp_timestamp_extension_inserter_core.sv
// RTP timestamp header-extension inserter.
//
// Packet bytes enter one word at a time on the in_ channel (byte, last mark and
// the current time in microseconds). Results leave on the out_ channel as
// groups of up to four bytes with a count, a last mark and a stamped flag.
// Every insert_period-th packet has its fixed header and CSRC list held in a
// small row memory; when the header is complete the header is released with
// the X bit set, followed by the 16-byte one-byte-form extension block.
//
// A byte that passes straight through is written to the output register when
// it is accepted; a new byte can be accepted as the last one is taken. A held
// header is released one group at a time: each row is read from the header
// memory (its read is registered) in ST_RD and loaded into the output register
// in ST_LOAD, starting after the word that completes the header or ends a
// short packet. Input is held off during a release. A stalled receiver holds
// the output register and, through it, the input.
// Reset (rst_n low, synchronous) returns to the start of a packet, phase zero
// and default registers; the memory is not cleared, only current bytes are read.
// The configuration port is always ready and must be written while idle.
module rtp_timestamp_extension_inserter_core
  import rtpts_pkg::*;
#(
  parameter int unsigned MAX_HEADER_BYTES = 72
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_in,
  input  logic [63:0] in_time_us,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_lane0,
  output logic [7:0]  out_lane1,
  output logic [7:0]  out_lane2,
  output logic [7:0]  out_lane3,
  output logic [2:0]  out_byte_count,
  output logic        out_last_out,
  output logic        out_stamped,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Rows of four bytes in the header memory, and the width of a group counter
  // that covers the header rows plus the four extension groups.
  localparam int unsigned ROWS   = (MAX_HEADER_BYTES + 3) / 4;
  localparam int unsigned ADDR_W = $clog2(ROWS);
  localparam int unsigned GRP_W  = $clog2(ROWS + EXT_GROUPS + 1);
  localparam logic [7:0]  MAX_HDR = 8'(MAX_HEADER_BYTES);

  // Configuration registers.
  logic [15:0] period_r;
  logic [3:0]  ext_id_r;

  // Packet state.
  rtpts_state_t     state_r, state_nxt;
  logic [15:0]      phase_r, phase_nxt;
  logic [6:0]       byte_index_r, byte_index_nxt;
  logic [6:0]       hlen_r, hlen_nxt;

  // Release bookkeeping.
  logic [GRP_W-1:0] row_r, row_nxt;
  logic [GRP_W-1:0] rel_total_r, rel_total_nxt;
  logic [1:0]       rel_tail_r, rel_tail_nxt;
  logic             rel_stamp_r, rel_stamp_nxt;
  logic             rel_last_r, rel_last_nxt;
  logic [63:0]      time_r;
  logic             time_load;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [3:0][7:0]  out_lanes_r, out_lanes_nxt;
  logic [2:0]       out_count_r, out_count_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_stamped_r, out_stamped_nxt;

  // Header memory ports.
  hdr_wr_t          mem_wr;
  logic [ADDR_W-1:0] mem_wr_row;
  logic [ADDR_W-1:0] mem_rd_row;
  logic [31:0]      mem_rd_data;

  logic             in_fire;
  logic             out_free;
  logic             in_state;
  logic [15:0]      phase_adv;
  logic [6:0]       start_hlen;
  logic             start_good;
  logic [6:0]       bi_inc;
  logic [7:0]       short_round;
  logic [GRP_W-1:0] hrows;
  logic [GRP_W-1:0] row_inc;
  logic [1:0]       ext_grp;
  logic [2:0]       tail_count;
  logic [3:0][7:0]  grp_bytes;
  logic [2:0]       grp_count;

  // Never stalls; the user must make writes land only while idle (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      ext_id_r <= EXT_ID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PERIOD: period_r <= cfg_data;
        CFG_EXT_ID: ext_id_r <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  rtpts_hdr_mem #(
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_hdr_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .wr_row  (mem_wr_row),
    .rd_row  (mem_rd_row),
    .rd_data (mem_rd_data)
  );

  // The memory is read continuously at the current release row. The row is
  // set in ST_RD and held into ST_LOAD, so the registered read data is ready
  // when its group is loaded. Rows past the header (extension groups) read a
  // harmless row.
  assign mem_rd_row = (row_r < GRP_W'(ROWS)) ? row_r[ADDR_W-1:0] : '0;

  assign out_free = !out_valid_r || out_ready;
  assign in_state = (state_r == ST_START) || (state_r == ST_COLLECT) ||
                    (state_r == ST_PLAIN) || (state_r == ST_STAMPED);
  assign in_ready = in_state && out_free;
  assign in_fire  = in_valid && in_ready;

  // Phase advance wraps to zero once phase+1 reaches the period.
  assign phase_adv = (({1'b0, phase_r} + 17'd1) >= {1'b0, period_r}) ? '0 : phase_r + 16'd1;

  // Header length from the first byte: 12 plus four per CSRC entry.
  assign start_hlen = FIXED_HDR_BYTES + {1'b0, in_byte_in[3:0], 2'b00};
  assign start_good = (in_byte_in[7:6] == RTP_VERSION) && ({1'b0, start_hlen} <= MAX_HDR);

  assign bi_inc      = byte_index_r + 7'd1;
  assign short_round = {1'b0, bi_inc} + 8'd3;
  assign hrows       = GRP_W'(hlen_r[6:2]);
  assign row_inc     = row_r + GRP_W'(1);
  assign ext_grp     = 2'(row_r - hrows);
  assign tail_count  = (rel_tail_r == 2'd0) ? 3'd4 : {1'b0, rel_tail_r};

  // Assemble the group for the current release row.
  always_comb begin
    grp_bytes = mem_rd_data;
    grp_count = 3'd4;
    if (rel_stamp_r) begin
      if (row_r == '0) begin
        grp_bytes[0] = mem_rd_data[7:0] | X_BIT_MASK;
      end
      if (row_r >= hrows) begin
        case (ext_grp)
          2'd0: grp_bytes = {EXT_LEN_LO, EXT_LEN_HI, EXT_PROFILE_LO, EXT_PROFILE_HI};
          2'd1: grp_bytes = {time_r[23:0], ext_id_r, EXT_ELEM_LEN};
          2'd2: grp_bytes = time_r[55:24];
          default: grp_bytes = {24'h000000, time_r[63:56]};
        endcase
      end
    end else if (row_inc == rel_total_r) begin
      // Final group of a short packet keeps only its valid bytes.
      grp_count = tail_count;
      for (int k = 0; k < 4; k++) begin
        if (3'(k) >= tail_count) begin
          grp_bytes[k] = 8'h00;
        end
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    hlen_nxt        = hlen_r;
    row_nxt         = row_r;
    rel_total_nxt   = rel_total_r;
    rel_tail_nxt    = rel_tail_r;
    rel_stamp_nxt   = rel_stamp_r;
    rel_last_nxt    = rel_last_r;
    time_load       = 1'b0;
    mem_wr          = '0;
    mem_wr_row      = byte_index_r[ADDR_W+1:2];
    out_valid_nxt   = out_valid_r && !out_ready;
    out_lanes_nxt   = out_lanes_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    out_stamped_nxt = out_stamped_r;

    case (state_r)
      ST_START: begin
        if (in_fire) begin
          if (phase_r == '0 && start_good && !in_last_in) begin
            // Picked packet: hold the first header byte and start collecting.
            mem_wr.en      = 1'b1;
            mem_wr.lane    = 2'd0;
            mem_wr.data    = in_byte_in;
            mem_wr_row     = '0;
            byte_index_nxt = 7'd1;
            hlen_nxt       = start_hlen;
            state_nxt      = ST_COLLECT;
          end else begin
            if (phase_r != '0) begin
              phase_nxt = phase_adv;
            end
            out_valid_nxt   = 1'b1;
            out_lanes_nxt   = {24'h000000, in_byte_in};
            out_count_nxt   = 3'd1;
            out_last_nxt    = in_last_in;
            out_stamped_nxt = 1'b0;
            state_nxt       = in_last_in ? ST_START : ST_PLAIN;
          end
        end
      end

      ST_COLLECT: begin
        if (in_fire) begin
          mem_wr.en      = 1'b1;
          mem_wr.lane    = byte_index_r[1:0];
          mem_wr.data    = in_byte_in;
          byte_index_nxt = bi_inc;
          if (bi_inc == hlen_r) begin
            // Header complete: stamp with the time of this word.
            time_load     = 1'b1;
            phase_nxt     = phase_adv;
            rel_stamp_nxt = 1'b1;
            rel_last_nxt  = in_last_in;
            rel_total_nxt = GRP_W'(hlen_r[6:2]) + GRP_W'(EXT_GROUPS);
            rel_tail_nxt  = 2'd0;
            row_nxt       = '0;
            state_nxt     = ST_RD;
          end else if (in_last_in) begin
            // Packet ended inside its header: release it unchanged.
            rel_stamp_nxt = 1'b0;
            rel_last_nxt  = 1'b1;
            rel_total_nxt = GRP_W'(short_round[7:2]);
            rel_tail_nxt  = bi_inc[1:0];
            row_nxt       = '0;
            state_nxt     = ST_RD;
          end
        end
      end

      ST_PLAIN, ST_STAMPED: begin
        if (in_fire) begin
          out_valid_nxt   = 1'b1;
          out_lanes_nxt   = {24'h000000, in_byte_in};
          out_count_nxt   = 3'd1;
          out_last_nxt    = in_last_in;
          out_stamped_nxt = (state_r == ST_STAMPED);
          if (in_last_in) begin
            state_nxt = ST_START;
          end
        end
      end

      ST_RD: begin
        state_nxt = ST_LOAD;
      end

      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_lanes_nxt   = grp_bytes;
          out_count_nxt   = grp_count;
          out_stamped_nxt = rel_stamp_r;
          out_last_nxt    = rel_last_r && (row_inc == rel_total_r);
          if (row_inc == rel_total_r) begin
            if (rel_stamp_r && !rel_last_r) begin
              state_nxt = ST_STAMPED;
            end else begin
              state_nxt = ST_START;
            end
          end else begin
            row_nxt   = row_inc;
            state_nxt = ST_RD;
          end
        end
      end

      default: state_nxt = ST_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_START;
      phase_r      <= '0;
      byte_index_r <= '0;
      hlen_r       <= FIXED_HDR_BYTES;
      row_r        <= '0;
      rel_total_r  <= '0;
      rel_tail_r   <= '0;
      rel_stamp_r  <= 1'b0;
      rel_last_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      hlen_r       <= hlen_nxt;
      row_r        <= row_nxt;
      rel_total_r  <= rel_total_nxt;
      rel_tail_r   <= rel_tail_nxt;
      rel_stamp_r  <= rel_stamp_nxt;
      rel_last_r   <= rel_last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_lanes_r   <= out_lanes_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
    out_stamped_r <= out_stamped_nxt;
    if (time_load) begin
      time_r <= in_time_us;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lane0      = out_lanes_r[0];
  assign out_lane1      = out_lanes_r[1];
  assign out_lane2      = out_lanes_r[2];
  assign out_lane3      = out_lanes_r[3];
  assign out_byte_count = out_count_r;
  assign out_last_out   = out_last_r;
  assign out_stamped    = out_stamped_r;

endmodule
